>>> design/mwto_pkg.sv
package mwto_pkg;

    // table geometry and sample format fixed by the stream fields
    localparam int TABLE_SIZE   = 2048;
    localparam int ADDR_W       = 11;
    localparam int SAMPLE_W     = 16;
    localparam int DIFF_W       = SAMPLE_W + 1;

    // register widths
    localparam int INC_W        = 26;
    localparam int Q16_W        = 16;
    localparam int CFG_W        = 26;
    localparam int CFG_IDX_W    = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INCREMENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_MIX       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LEVEL    = 2'd2;

    // operation codes carried in tuser
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK        = 2'd2;
    localparam logic [OP_W-1:0] OP_RESTART     = 2'd3;

    // stream payload widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;

endpackage

>>> design/mwto_ram.sv
module mwto_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/morphing_wavetable_oscillator_unit.sv
// Two-table wavetable oscillator with linear interpolation and crossfade.
//
// Input stream (s_*): each request carries an operation in tuser. Loads
// write one entry of the first or second table and restart clears the
// phase; both finish in the accept cycle and give no output. A tick reads
// two neighboring entries of each table at the current phase, interpolates
// by the phase fraction, crossfades by table_mix and scales by output_level.
// Output stream (m_*): one signed sample per tick.
//
// Sequencing: a tick walks an eleven-state sequencer around a single shared
// 17 x (max(F,16)+1) bit multiplier (four products) and the one read port of
// each table RAM; its sample is registered as the sequencer leaves S_OUT,
// and no new request is taken until the sequencer is back in S_IDLE.
// A tick with zero increment skips the arithmetic, goes straight to S_OUT and gives 0.
// Loads and restarts are taken every cycle while the unit is idle.
//
// Reset clears the phase, the registers and the sequencer; table contents
// are undefined until loaded. While the receiver stalls, the finished
// sample waits in the output register; loads and restarts are still
// taken, and a following tick waits in its last state until it is free.
module morphing_wavetable_oscillator_unit
    import mwto_pkg::*;
#(
    parameter int PHASE_FRACTION_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [10:0] table_address, [26:11] table_value
    input  logic [OP_W-1:0]       s_tuser,   // [1:0] operation
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [15:0] sample_out
);

    localparam int F      = PHASE_FRACTION_BITS;
    localparam int PH_W   = ADDR_W + F;
    localparam int SUM_W  = (PH_W > INC_W) ? PH_W : INC_W;
    localparam int MB_W   = (F > Q16_W) ? F : Q16_W;
    localparam int PROD_W = DIFF_W + MB_W + 1;

    // sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE = 4'd0;
    localparam logic [ST_W-1:0] S_RD0  = 4'd1;
    localparam logic [ST_W-1:0] S_RD1  = 4'd2;
    localparam logic [ST_W-1:0] S_DIF  = 4'd3;
    localparam logic [ST_W-1:0] S_M1   = 4'd4;
    localparam logic [ST_W-1:0] S_M2   = 4'd5;
    localparam logic [ST_W-1:0] S_M3   = 4'd6;
    localparam logic [ST_W-1:0] S_M4   = 4'd7;
    localparam logic [ST_W-1:0] S_M5   = 4'd8;
    localparam logic [ST_W-1:0] S_M6   = 4'd9;
    localparam logic [ST_W-1:0] S_OUT  = 4'd10;

    logic [ST_W-1:0]     state_reg, state_next;
    logic [PH_W-1:0]     phase_reg, phase_next;
    logic [INC_W-1:0]    inc_reg, inc_next;
    logic [Q16_W-1:0]    mix_reg, mix_next;
    logic [Q16_W-1:0]    level_reg, level_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg, out_data_next;
    logic                zero_reg, zero_next;

    sample_t             a1_reg, a1_next;
    sample_t             a2_reg, a2_next;
    diff_t               d1_reg, d1_next;
    diff_t               d2_reg, d2_next;
    sample_t             l_reg, l_next;
    diff_t               dm_reg, dm_next;
    sample_t             mixed_reg, mixed_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    logic                in_acc;
    logic [OP_W-1:0]     in_op;
    logic [ADDR_W-1:0]   in_addr;
    logic [SAMPLE_W-1:0] in_value;
    logic                out_free;

    logic [ADDR_W-1:0]   idx;
    logic [F-1:0]        frac;
    logic [ADDR_W-1:0]   raddr;
    logic [SAMPLE_W-1:0] rd1, rd2;
    logic [SUM_W-1:0]    phase_sum;

    diff_t               mul_a;
    logic [MB_W-1:0]     mul_b;
    logic signed [PROD_W-1:0] prod_sh_f, prod_sh_q;
    sample_t             r_val;

    // request fields
    assign in_op    = s_tuser;
    assign in_addr  = s_tdata[ADDR_W-1:0];
    assign in_value = s_tdata[ADDR_W +: SAMPLE_W];
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // phase split and table read address
    assign idx   = phase_reg[PH_W-1:F];
    assign frac  = phase_reg[F-1:0];
    assign raddr = (state_reg == S_RD1) ? (idx + ADDR_W'(1)) : idx;

    // table memories
    mwto_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_SIZE)
    ) u_first_table (
        .clk   (clk),
        .we    (in_acc && (in_op == OP_LOAD_FIRST)),
        .waddr (in_addr),
        .wdata (in_value),
        .raddr (raddr),
        .rdata (rd1)
    );

    mwto_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_SIZE)
    ) u_second_table (
        .clk   (clk),
        .we    (in_acc && (in_op == OP_LOAD_SECOND)),
        .waddr (in_addr),
        .wdata (in_value),
        .raddr (raddr),
        .rdata (rd2)
    );

    // shared multiplier operand select, the level product is held while the output waits
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_M1:
            begin
                mul_a = d1_reg;
                mul_b = MB_W'(frac);
            end
            S_M2:
            begin
                mul_a = d2_reg;
                mul_b = MB_W'(frac);
            end
            S_M4:
            begin
                mul_a = dm_reg;
                mul_b = MB_W'(mix_reg);
            end
            S_M6, S_OUT:
            begin
                mul_a = DIFF_W'(mixed_reg);
                mul_b = MB_W'(level_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * $signed({1'b0, mul_b});
    assign prod_sh_f = prod_reg >>> F;
    assign prod_sh_q = prod_reg >>> Q16_W;
    assign r_val     = a2_reg + sample_t'(prod_sh_f[SAMPLE_W-1:0]);

    // phase advance wraps at the table length
    assign phase_sum = SUM_W'(phase_reg) + SUM_W'(inc_reg);

    // sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        inc_next       = inc_reg;
        mix_next       = mix_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        zero_next      = zero_reg;
        a1_next        = a1_reg;
        a2_next        = a2_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        l_next         = l_reg;
        dm_next        = dm_reg;
        mixed_next     = mixed_reg;

        // configuration writes
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PHASE_INCREMENT: inc_next   = cfg_data[INC_W-1:0];
                REG_TABLE_MIX:       mix_next   = cfg_data[Q16_W-1:0];
                REG_OUTPUT_LEVEL:    level_next = cfg_data[Q16_W-1:0];
                default:             inc_next   = inc_reg;
            endcase
        end

        // output register drains on request
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_op == OP_RESTART)
                    begin
                        phase_next = '0;
                    end
                    else if (in_op == OP_TICK)
                    begin
                        zero_next  = (inc_reg == '0);
                        state_next = (inc_reg == '0) ? S_OUT : S_RD0;
                    end
                end
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                a1_next    = rd1;
                a2_next    = rd2;
                state_next = S_DIF;
            end
            S_DIF:
            begin
                d1_next    = DIFF_W'($signed(rd1)) - DIFF_W'(a1_reg);
                d2_next    = DIFF_W'($signed(rd2)) - DIFF_W'(a2_reg);
                state_next = S_M1;
            end
            S_M1:
            begin
                state_next = S_M2;
            end
            S_M2:
            begin
                l_next     = a1_reg + sample_t'(prod_sh_f[SAMPLE_W-1:0]);
                state_next = S_M3;
            end
            S_M3:
            begin
                dm_next    = DIFF_W'(r_val) - DIFF_W'(l_reg);
                state_next = S_M4;
            end
            S_M4:
            begin
                state_next = S_M5;
            end
            S_M5:
            begin
                mixed_next = l_reg + sample_t'(prod_sh_q[SAMPLE_W-1:0]);
                state_next = S_M6;
            end
            S_M6:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = zero_reg ? '0 : prod_sh_q[SAMPLE_W-1:0];
                    if (!zero_reg)
                    begin
                        phase_next = phase_sum[PH_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            inc_reg       <= '0;
            mix_reg       <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            inc_reg       <= inc_next;
            mix_reg       <= mix_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        zero_reg     <= zero_next;
        a1_reg       <= a1_next;
        a2_reg       <= a2_next;
        d1_reg       <= d1_next;
        d2_reg       <= d2_next;
        l_reg        <= l_next;
        dm_reg       <= dm_next;
        mixed_reg    <= mixed_next;
        prod_reg     <= prod_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // restart clears the phase
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_op == OP_RESTART)) |=> (phase_reg == '0))
        else $error("phase not cleared after restart");

    // a silent tick leaves the phase alone
    a_zero_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_op == OP_TICK) && (inc_reg == '0)) |=> $stable(phase_reg))
        else $error("phase moved on a zero-increment tick");

    // a tick blocks further requests until its sample is out
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_op == OP_TICK)) |=> !s_tready)
        else $error("request accepted while a tick is in progress");

    // a finished sample lands in a free output register
    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_free) |=> (m_tvalid && (state_reg == S_IDLE)))
        else $error("finished sample not presented");

endmodule

>>> tb/tb_morphing_wavetable_oscillator_unit.sv
module tb_morphing_wavetable_oscillator_unit;
    import mwto_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int PHASE_W        = ADDR_W + FRAC_BITS;
    localparam longint Q16_ONE    = 65536;
    localparam int DRAIN_CYCLES   = 16;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 69;
    localparam int HOLD_AFTER     = 60;
    localparam int HOLD_CYCLES    = 300;
    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        sample_t           value;
    } osc_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_PHASE_INCREMENT;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;    // [10:0] table_address, [26:11] table_value
    logic [OP_W-1:0]       s_tuser = OP_LOAD_FIRST;  // [1:0] operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [15:0] sample_out

    morphing_wavetable_oscillator_unit #(
        .PHASE_FRACTION_BITS (FRAC_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    // oscillator state mirrored at request acceptance
    logic [PHASE_W-1:0] osc_phase = '0;
    sample_t            wave_first [TABLE_SIZE];
    sample_t            wave_second [TABLE_SIZE];
    logic [INC_W-1:0]   cur_increment = '0;
    logic [Q16_W-1:0]   cur_mix = '0;
    logic [Q16_W-1:0]   cur_level = '0;
    sample_t            expected_samples [$];

    // request planning state, runs ahead of the block
    osc_req_t           pending_reqs [$];
    logic [PHASE_W-1:0] plan_phase = '0;
    logic [INC_W-1:0]   plan_increment = '0;
    bit                 loaded_first [TABLE_SIZE];
    bit                 loaded_second [TABLE_SIZE];
    int                 planned_items = 0;

    // run bookkeeping
    int  n_loads = 0;
    int  n_ticks = 0;
    int  n_restarts = 0;
    int  settings_used = 0;
    int  samples_checked = 0;
    int  mismatch_count = 0;
    bit  src_idle_en = 1'b0;
    bit  sink_idle_en = 1'b0;
    int  unsigned cycle_count = 0;

    // linear interpolation between two neighboring entries
    function automatic longint lerp_entry(sample_t a, sample_t b, longint frac);
        return (longint'(a) * (Q16_ONE - frac) + longint'(b) * frac) >>> FRAC_BITS;
    endfunction

    // apply one accepted request to the mirrored state
    task automatic apply_request(input osc_req_t req);
        longint idx;
        longint idx_next;
        longint frac;
        longint left;
        longint right;
        longint mixed;
        longint level_out;
        case (req.op)
            OP_LOAD_FIRST:
            begin
                wave_first[req.addr] = req.value;
                n_loads++;
            end
            OP_LOAD_SECOND:
            begin
                wave_second[req.addr] = req.value;
                n_loads++;
            end
            OP_RESTART:
            begin
                osc_phase = '0;
                n_restarts++;
            end
            OP_TICK:
            begin
                level_out = 0;
                if (cur_increment != '0)
                begin
                    idx = longint'(osc_phase >> FRAC_BITS);
                    idx_next = (idx + 1) % TABLE_SIZE;
                    frac = longint'(osc_phase[FRAC_BITS-1:0]);
                    left = lerp_entry(wave_first[idx], wave_first[idx_next], frac);
                    right = lerp_entry(wave_second[idx], wave_second[idx_next], frac);
                    mixed = (left * (Q16_ONE - longint'(cur_mix))
                             + right * longint'(cur_mix)) >>> 16;
                    level_out = (mixed * longint'(cur_level)) >>> 16;
                    if (level_out > longint'(SAMPLE_MAX))
                        level_out = longint'(SAMPLE_MAX);
                    if (level_out < longint'(SAMPLE_MIN))
                        level_out = longint'(SAMPLE_MIN);
                    osc_phase = osc_phase + cur_increment;
                end
                expected_samples.push_back(sample_t'(level_out));
                n_ticks++;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic plan_load(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input sample_t value);
        osc_req_t req;
        req.op = op;
        req.addr = addr;
        req.value = value;
        pending_reqs.push_back(req);
        if (op == OP_LOAD_FIRST)
            loaded_first[addr] = 1'b1;
        else
            loaded_second[addr] = 1'b1;
        planned_items++;
    endtask

    task automatic plan_restart();
        osc_req_t req;
        req.op = OP_RESTART;
        req.addr = ADDR_W'($urandom);
        req.value = sample_t'($urandom);
        pending_reqs.push_back(req);
        plan_phase = '0;
        planned_items++;
    endtask

    // a tick, preceded by loads of any entry it reads that is still unwritten
    task automatic plan_tick();
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] idx_next;
        osc_req_t          req;
        if (plan_increment != '0)
        begin
            idx = plan_phase[PHASE_W-1:FRAC_BITS];
            idx_next = idx + 1'b1;
            if (!loaded_first[idx])
                plan_load(OP_LOAD_FIRST, idx, sample_t'($urandom));
            if (!loaded_first[idx_next])
                plan_load(OP_LOAD_FIRST, idx_next, sample_t'($urandom));
            if (!loaded_second[idx])
                plan_load(OP_LOAD_SECOND, idx, sample_t'($urandom));
            if (!loaded_second[idx_next])
                plan_load(OP_LOAD_SECOND, idx_next, sample_t'($urandom));
            plan_phase = plan_phase + plan_increment;
        end
        req.op = OP_TICK;
        req.addr = ADDR_W'($urandom);
        req.value = sample_t'($urandom);
        pending_reqs.push_back(req);
        planned_items++;
    endtask

    task automatic plan_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            plan_tick();
        else if (pick < 70)
            plan_load(OP_LOAD_FIRST, ADDR_W'($urandom), sample_t'($urandom));
        else if (pick < 95)
            plan_load(OP_LOAD_SECOND, ADDR_W'($urandom), sample_t'($urandom));
        else
            plan_restart();
    endtask

    // wait until every request is taken and every sample has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_samples.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        case (index)
            REG_PHASE_INCREMENT: cur_increment = data[INC_W-1:0];
            REG_TABLE_MIX:       cur_mix = data[Q16_W-1:0];
            REG_OUTPUT_LEVEL:    cur_level = data[Q16_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_regs(input logic [INC_W-1:0] inc, input logic [Q16_W-1:0] mix,
                            input logic [Q16_W-1:0] level);
        wait_idle();
        write_reg(REG_PHASE_INCREMENT, CFG_W'(inc));
        write_reg(REG_TABLE_MIX, CFG_W'(mix));
        write_reg(REG_OUTPUT_LEVEL, CFG_W'(level));
        @(posedge clk);
        cfg_write <= 1'b0;
        plan_increment = inc;
        settings_used++;
    endtask

    // request driver with random gaps
    osc_req_t offered_req;
    int       src_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= OP_LOAD_FIRST;
            src_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_request(offered_req);
            if (!s_tvalid || s_tready)
            begin
                if (src_gap == 0 && src_idle_en && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 8);
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    offered_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= IN_DATA_W'({offered_req.value, offered_req.addr});
                    s_tuser <= offered_req.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready: random stalls plus one long hold-off
    int sink_gap = 0;
    int long_hold_left = 0;
    bit long_hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (!long_hold_done && samples_checked == HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                long_hold_left = HOLD_CYCLES;
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                m_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // sample checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample_out: no tick waiting, actual %0d",
                       $signed(m_tdata[SAMPLE_W-1:0]));
                mismatch_count++;
            end
            else
            begin
                if (m_tdata[SAMPLE_W-1:0] !== expected_samples[0])
                begin
                    $error("sample_out: expected %0d, actual %0d",
                           expected_samples[0], $signed(m_tdata[SAMPLE_W-1:0]));
                    mismatch_count++;
                end
                void'(expected_samples.pop_front());
            end
            samples_checked <= samples_checked + 1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        int               phase_end;
        logic [INC_W-1:0] inc;
        logic [Q16_W-1:0] mix;
        logic [Q16_W-1:0] level;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: zero increment gives silence and holds the phase
        plan_tick();
        plan_restart();
        plan_tick();
        set_regs('0, '0, '0);

        // full-scale table values, one and a half positions per tick
        set_regs(26'h18000, 16'h0000, 16'hFFFF);
        plan_load(OP_LOAD_FIRST, 11'd0, SAMPLE_MAX);
        plan_load(OP_LOAD_FIRST, 11'd1, SAMPLE_MIN);
        plan_load(OP_LOAD_FIRST, 11'd2, SAMPLE_MAX);
        plan_load(OP_LOAD_SECOND, 11'd0, SAMPLE_MIN);
        plan_load(OP_LOAD_SECOND, 11'd1, SAMPLE_MAX);
        plan_load(OP_LOAD_SECOND, 11'd2, SAMPLE_MIN);
        repeat (2) plan_tick();
        plan_restart();
        plan_tick();

        // largest fraction, full second table, full level
        set_regs(26'h0FFFF, 16'hFFFF, 16'hFFFF);
        repeat (2) plan_tick();

        // largest increment, just under half the table length per tick
        set_regs(26'h3FFFFFF, 16'h8000, 16'hFFFF);
        repeat (2) plan_tick();

        // zero increment with nonzero level still gives silence
        set_regs('0, 16'hFFFF, 16'hFFFF);
        repeat (2) plan_tick();

        // random settings, each with a batch of random requests
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 5))
                0: inc = '0;
                1: inc = 26'h3FFFFFF;
                2: inc = INC_W'($urandom_range(1, 32'h3FFFF));
                3: inc = INC_W'($urandom);
                4: inc = ($urandom_range(0, 1) == 0) ? 26'h1 : 26'h0FFFF;
                default: inc = INC_W'($urandom_range(1, 4)) << FRAC_BITS;
            endcase
            case ($urandom_range(0, 3))
                0: mix = '0;
                1: mix = 16'hFFFF;
                default: mix = Q16_W'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: level = '0;
                1: level = 16'hFFFF;
                default: level = Q16_W'($urandom);
            endcase
            set_regs(inc, mix, level);
            src_idle_en = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_idle_en = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            phase_end = planned_items + PHASE_ITEMS;
            while (planned_items < phase_end)
                plan_random_item();
        end

        wait_idle();
        $display("covered %0d loads, %0d ticks and %0d restarts over %0d register settings",
                 n_loads, n_ticks, n_restarts, settings_used);
        $display("%0d samples compared, %0d mismatches", samples_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
design/mwto_pkg.sv
design/mwto_ram.sv
design/morphing_wavetable_oscillator_unit.sv
tb/tb_morphing_wavetable_oscillator_unit.sv
